### rtl/kpd_pkg.sv
// Shared types and constants for the keypad debounce and auto-repeat block.
// No dependencies; used by kpd_lane, kpd_merge and keypad_debounce_autorepeat.
package kpd_pkg;

  localparam int ROWS  = 4;
  localparam int ROW_W = 2;
  localparam int COL_W = 3;
  localparam int CFG_W = 10;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] CFG_HOLD_DELAY      = 2'd0;
  localparam logic [IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;

  typedef struct packed {
    logic            take;
    logic            steady;
  } lane_ctl_t;

  typedef struct packed {
    logic [ROWS-1:0] code;
    logic [ROWS-1:0] rise;
    logic            match;
  } lane_stat_t;

endpackage

### rtl/kpd_lane.sv
// One column lane: one-hot row code, steady match and newly pressed row.
// Holds the column's previous reading and remembered pressed code. Uses kpd_pkg.
module kpd_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [kpd_pkg::ROWS-1:0]       raw,
  input  kpd_pkg::lane_ctl_t             ctl,
  output kpd_pkg::lane_stat_t            stat
);

  logic [kpd_pkg::ROWS-1:0] last_reading;
  logic [kpd_pkg::ROWS-1:0] pressed_seen;
  logic [kpd_pkg::ROWS-1:0] code;

  // highest-numbered pressed row wins, row r coded as 8 >> r
  always_comb begin
    code = '0;
    for (int r = 0; r < kpd_pkg::ROWS; r++) begin
      if (raw[r]) begin
        code = '0;
        code[kpd_pkg::ROWS-1-r] = 1'b1;
      end
    end
  end

  assign stat.code  = code;
  assign stat.match = (code != '0) && (code == last_reading);
  assign stat.rise  = code & ~pressed_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_reading <= '0;
      pressed_seen <= '0;
    end else if (ctl.take) begin
      last_reading <= code;
      pressed_seen <= ctl.steady ? code : '0;
    end
  end

endmodule

### rtl/kpd_merge.sv
// Merge of the column lanes: steady flag and first new key in column-major order.
// Uses kpd_pkg lane status structs.
module kpd_merge #(
  parameter int NUM_COLUMNS = 3,
  parameter int NUM_KEYS    = 12
) (
  input  kpd_pkg::lane_stat_t                            lanes [NUM_COLUMNS],
  output logic                                           steady,
  output logic                                           pressed,
  output logic [kpd_pkg::COL_W+kpd_pkg::ROW_W-1:0]       key
);

  localparam int KEY_W = kpd_pkg::COL_W + kpd_pkg::ROW_W;

  logic                      found;
  logic [kpd_pkg::COL_W-1:0] col;
  logic [kpd_pkg::ROWS-1:0]  rise;
  logic [kpd_pkg::ROW_W-1:0] row;

  always_comb begin
    steady = 1'b0;
    found  = 1'b0;
    col    = '0;
    rise   = '0;
    for (int c = NUM_COLUMNS - 1; c >= 0; c--) begin
      if (lanes[c].match) begin
        steady = 1'b1;
      end
      if (lanes[c].rise != '0) begin
        found = 1'b1;
        col   = kpd_pkg::COL_W'(c);
        rise  = lanes[c].rise;
      end
    end
  end

  always_comb begin
    row = '0;
    for (int r = 0; r < kpd_pkg::ROWS; r++) begin
      if (rise[kpd_pkg::ROWS-1-r]) begin
        row = kpd_pkg::ROW_W'(r);
      end
    end
  end

  assign key     = {col, row};
  assign pressed = found && ((KEY_W + 1)'(key) < (KEY_W + 1)'(NUM_KEYS));

endmodule

### rtl/keypad_debounce_autorepeat.sv
// Top level of the keypad debounce and auto-repeat block.
// Instantiates kpd_lane per column and kpd_merge; uses kpd_pkg.
//
// Each accepted word is one scan of a 4-row key matrix, one column lane per
// column working in parallel. A scan is accepted every clock cycle; its press
// or repeat word, if any, appears in the output register on the next cycle.
// The input side stalls only while that output register holds a word the
// consumer has not yet taken. Hold delay and repeat interval count in scans
// and are loaded through the configuration port; write them only while idle.
module keypad_debounce_autorepeat #(
  parameter int NUM_COLUMNS   = 3,
  parameter int NUM_KEYS      = 12,
  parameter int COUNTER_WIDTH = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kpd_pkg::ROWS*NUM_COLUMNS-1:0] key_matrix,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [3:0]                           key_index,
  output logic                                 is_repeat,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kpd_pkg::IDX_W-1:0]            cfg_index,
  input  logic [kpd_pkg::CFG_W-1:0]            cfg_data
);

  localparam int KEY_W = kpd_pkg::COL_W + kpd_pkg::ROW_W;

  logic [COUNTER_WIDTH-1:0] hold_delay;
  logic [COUNTER_WIDTH-1:0] repeat_interval;
  logic                     repeat_armed;
  logic [3:0]               held_key;
  logic [COUNTER_WIDTH-1:0] hold_counter;
  logic [COUNTER_WIDTH-1:0] repeat_counter;
  logic [COUNTER_WIDTH-1:0] hold_dec;
  logic [COUNTER_WIDTH-1:0] repeat_dec;

  kpd_pkg::lane_ctl_t  ctl;
  kpd_pkg::lane_stat_t lanes [NUM_COLUMNS];
  logic                steady;
  logic                pressed;
  logic [KEY_W-1:0]    key;
  logic                take;
  logic                fire_repeat;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;

  assign ctl.take   = take;
  assign ctl.steady = steady;

  for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_lane
    kpd_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .raw  (key_matrix[kpd_pkg::ROWS*c +: kpd_pkg::ROWS]),
      .ctl  (ctl),
      .stat (lanes[c])
    );
  end

  kpd_merge #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_KEYS    (NUM_KEYS)
  ) u_merge (
    .lanes   (lanes),
    .steady  (steady),
    .pressed (pressed),
    .key     (key)
  );

  assign hold_dec    = (hold_counter != '0) ? hold_counter - 1'b1 : '0;
  assign repeat_dec  = (repeat_counter != '0) ? repeat_counter - 1'b1 : '0;
  assign fire_repeat = steady && !pressed && repeat_armed
                       && (hold_dec == '0) && (repeat_dec == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_delay      <= COUNTER_WIDTH'(50);
      repeat_interval <= COUNTER_WIDTH'(10);
    end else if (cfg_valid) begin
      if (cfg_index == kpd_pkg::CFG_HOLD_DELAY) begin
        hold_delay <= COUNTER_WIDTH'(cfg_data);
      end else if (cfg_index == kpd_pkg::CFG_REPEAT_INTERVAL) begin
        repeat_interval <= COUNTER_WIDTH'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_armed   <= 1'b0;
      held_key       <= '0;
      hold_counter   <= '0;
      repeat_counter <= '0;
      out_valid      <= 1'b0;
    end else if (take) begin
      out_valid <= steady && (pressed || fire_repeat);
      if (!steady) begin
        repeat_armed   <= 1'b0;
        repeat_counter <= '0;
        hold_counter   <= hold_dec;
      end else if (pressed) begin
        repeat_armed   <= 1'b1;
        held_key       <= key[3:0];
        hold_counter   <= hold_delay;
        repeat_counter <= repeat_dec;
      end else if (fire_repeat) begin
        hold_counter   <= hold_dec;
        repeat_counter <= repeat_interval;
      end else begin
        hold_counter   <= hold_dec;
        repeat_counter <= repeat_dec;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_index <= pressed ? key[3:0] : held_key;
      is_repeat <= !pressed;
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for keypad_debounce_autorepeat: scan words in, press and repeat words out.
// Checks each output word against typed rows or the predictor; needs kpd_pkg and the top level.
module tb;

  localparam int COLS  = 3;
  localparam int KEYS  = 12;
  localparam int MAT_W = kpd_pkg::ROWS * COLS;

  typedef enum logic [1:0] {ROW_SCAN, ROW_HOLD, ROW_REPEAT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [MAT_W-1:0]   value;
    logic               typed;
    logic               fires;
    logic [3:0]         key;
    logic               rep;
  } dir_row_t;

  typedef struct packed {
    logic [3:0] key;
    logic       rep;
  } key_event_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [MAT_W-1:0]           key_matrix = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [3:0]                 key_index;
  logic                       is_repeat;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [kpd_pkg::IDX_W-1:0]  cfg_index = kpd_pkg::CFG_HOLD_DELAY;
  logic [kpd_pkg::CFG_W-1:0]  cfg_data = '0;

  keypad_debounce_autorepeat u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_matrix (key_matrix),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_index  (key_index),
    .is_repeat  (is_repeat),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scan predictor state
  logic [3:0]               prev_code [COLS] = '{default: '0};
  logic [3:0]               seen_code [COLS] = '{default: '0};
  logic                     rpt_armed = 1'b0;
  logic [3:0]               held_idx = '0;
  logic [kpd_pkg::CFG_W-1:0] hold_left = '0;
  logic [kpd_pkg::CFG_W-1:0] rpt_left = '0;
  logic [kpd_pkg::CFG_W-1:0] hold_cfg = 10'd50;
  logic [kpd_pkg::CFG_W-1:0] rpt_cfg = 10'd10;

  key_event_t key_events_due [$];

  int  n_errors = 0;
  int  n_scans = 0;
  int  n_press = 0;
  int  n_repeat = 0;
  int  n_cfg = 0;
  int  send_idle_pct = 0;
  int  sink_idle_pct = 0;
  bit  sink_hold = 1'b0;

  bit         cur_typed = 1'b0;
  bit         cur_fires = 1'b0;
  logic [3:0] cur_key = '0;
  bit         cur_rep = 1'b0;

  dir_row_t dir_rows [30] = '{
    '{ROW_SCAN,   12'h000, 1'b1, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h001, 1'b1, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h001, 1'b1, 1'b1, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h001, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h800, 1'b1, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h800, 1'b1, 1'b1, 4'd11, 1'b0},
    '{ROW_SCAN,   12'hFFF, 1'b1, 1'b1, 4'd3,  1'b0},
    '{ROW_SCAN,   12'h0F0, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h0A5, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_HOLD,   12'h000, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_REPEAT, 12'h000, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h010, 1'b1, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h010, 1'b1, 1'b1, 4'd4,  1'b0},
    '{ROW_SCAN,   12'h010, 1'b1, 1'b1, 4'd4,  1'b1},
    '{ROW_SCAN,   12'h010, 1'b1, 1'b1, 4'd4,  1'b1},
    '{ROW_SCAN,   12'h110, 1'b1, 1'b1, 4'd8,  1'b0},
    '{ROW_SCAN,   12'h010, 1'b1, 1'b1, 4'd8,  1'b1},
    '{ROW_HOLD,   12'h3FF, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_REPEAT, 12'h3FF, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h002, 1'b1, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h002, 1'b1, 1'b1, 4'd1,  1'b0},
    '{ROW_SCAN,   12'h002, 1'b1, 1'b0, 4'd0,  1'b0},
    '{ROW_HOLD,   12'h002, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_REPEAT, 12'h001, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h040, 1'b1, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h040, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h040, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h040, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h040, 1'b0, 1'b0, 4'd0,  1'b0},
    '{ROW_SCAN,   12'h040, 1'b0, 1'b0, 4'd0,  1'b0}
  };

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 50) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic scan_keypad(input logic [MAT_W-1:0] m, output bit fired,
                             output key_event_t ev);
    logic [3:0] code [COLS];
    logic [3:0] rise [COLS];
    bit steady;
    bit hit;
    fired = 1'b0;
    ev = '0;
    steady = 1'b0;
    hit = 1'b0;
    if (hold_left != 0) hold_left = hold_left - 1'b1;
    if (rpt_left != 0) rpt_left = rpt_left - 1'b1;
    for (int c = 0; c < COLS; c++) begin
      code[c] = '0;
      for (int r = 0; r < kpd_pkg::ROWS; r++) begin
        if (m[kpd_pkg::ROWS * c + r]) code[c] = 4'h8 >> r;
      end
      if (code[c] != 0 && code[c] == prev_code[c]) steady = 1'b1;
    end
    if (steady) begin
      for (int c = 0; c < COLS; c++) begin
        rise[c] = code[c] & ~seen_code[c];
        seen_code[c] = code[c];
      end
      for (int k = 0; k < KEYS; k++) begin
        if (!hit && rise[k / kpd_pkg::ROWS][3 - k % kpd_pkg::ROWS]) begin
          hit = 1'b1;
          held_idx = 4'(k);
          rpt_armed = 1'b1;
          hold_left = hold_cfg;
          fired = 1'b1;
          ev.key = 4'(k);
          ev.rep = 1'b0;
        end
      end
      if (!hit && rpt_armed && hold_left == 0 && rpt_left == 0) begin
        rpt_left = rpt_cfg;
        fired = 1'b1;
        ev.key = held_idx;
        ev.rep = 1'b1;
      end
    end else begin
      rpt_armed = 1'b0;
      rpt_left = '0;
      for (int c = 0; c < COLS; c++) seen_code[c] = '0;
    end
    prev_code = code;
  endtask

  always @(posedge clk) begin : monitor
    bit fired;
    key_event_t ev;
    if (!rst) begin
      if (in_valid && in_ready) begin
        n_scans++;
        scan_keypad(key_matrix, fired, ev);
        if (cur_typed) begin
          fired = cur_fires;
          ev.key = cur_key;
          ev.rep = cur_rep;
        end
        if (fired) key_events_due.push_back(ev);
      end
      if (out_valid && out_ready) begin
        if (key_events_due.size() == 0) begin
          flag_error($sformatf("unexpected word key_index=%0d is_repeat=%0b",
                               key_index, is_repeat));
        end else begin
          ev = key_events_due.pop_front();
          if (key_index !== ev.key)
            flag_error($sformatf("key_index %0d, expected %0d", key_index, ev.key));
          if (is_repeat !== ev.rep)
            flag_error($sformatf("is_repeat %0b, expected %0b", is_repeat, ev.rep));
          if (ev.rep) n_repeat++;
          else n_press++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_scan(input logic [MAT_W-1:0] m, input bit typed, input bit fires,
                           input logic [3:0] key, input bit rep);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    key_matrix <= m;
    cur_typed = typed;
    cur_fires = fires;
    cur_key = key;
    cur_rep = rep;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [kpd_pkg::IDX_W-1:0] idx,
                           input logic [kpd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == kpd_pkg::CFG_HOLD_DELAY) hold_cfg = val;
    else rpt_cfg = val;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, drain outstanding words, then let the pipeline empty
  task automatic settle();
    int guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (key_events_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [MAT_W-1:0] key_bits();
    int col;
    int row;
    logic [MAT_W-1:0] bits;
    col = $urandom_range(COLS - 1);
    row = $urandom_range(kpd_pkg::ROWS - 1);
    bits = '0;
    bits[kpd_pkg::ROWS * col + row] = 1'b1;
    if ($urandom_range(1))
      bits = bits | MAT_W'(($urandom_range(15) & ((1 << row) - 1))
                           << (kpd_pkg::ROWS * col));
    return bits;
  endfunction

  task automatic run_random(input int n_items, input bit pause_midway);
    logic [MAT_W-1:0] pat;
    int run;
    int sent;
    bit paused;
    pat = '0;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: pat = key_bits();
        4, 5:       pat = pat | key_bits();
        6:          pat = MAT_W'($urandom_range(12'hFFF));
        7:          pat = '0;
        default:    pat = pat ^ (12'h1 << $urandom_range(MAT_W - 1));
      endcase
      run = ($urandom_range(4) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      if ($urandom_range(3) == 0) begin
        send_scan(MAT_W'($urandom_range(12'hFFF)), 1'b0, 1'b0, 4'd0, 1'b0);
        sent++;
      end
      repeat (run) begin
        send_scan(pat, 1'b0, 1'b0, 4'd0, 1'b0);
        sent++;
      end
      if (pause_midway && !paused && sent >= n_items / 2) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (key_events_due.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    sink_idle_pct = 75;
    for (int i = 0; i < $size(dir_rows); i++) begin
      case (dir_rows[i].kind)
        ROW_SCAN: send_scan(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].fires,
                            dir_rows[i].key, dir_rows[i].rep);
        ROW_HOLD: begin
          settle();
          write_reg(kpd_pkg::CFG_HOLD_DELAY, dir_rows[i].value[kpd_pkg::CFG_W-1:0]);
        end
        default: begin
          settle();
          write_reg(kpd_pkg::CFG_REPEAT_INTERVAL, dir_rows[i].value[kpd_pkg::CFG_W-1:0]);
        end
      endcase
    end

    for (int s = 0; s < 6; s++) begin
      settle();
      case (s)
        0: begin
          write_reg(kpd_pkg::CFG_HOLD_DELAY, kpd_pkg::CFG_W'($urandom_range(6)));
          write_reg(kpd_pkg::CFG_REPEAT_INTERVAL, kpd_pkg::CFG_W'($urandom_range(4)));
        end
        1: begin
          write_reg(kpd_pkg::CFG_HOLD_DELAY, 10'd0);
          write_reg(kpd_pkg::CFG_REPEAT_INTERVAL, kpd_pkg::CFG_W'($urandom_range(2)));
        end
        2: begin
          write_reg(kpd_pkg::CFG_HOLD_DELAY, kpd_pkg::CFG_W'($urandom_range(10, 1)));
          write_reg(kpd_pkg::CFG_REPEAT_INTERVAL, 10'd1023);
        end
        4: begin
          write_reg(kpd_pkg::CFG_HOLD_DELAY, 10'd0);
          write_reg(kpd_pkg::CFG_REPEAT_INTERVAL, 10'd0);
        end
        default: begin
          write_reg(kpd_pkg::CFG_HOLD_DELAY, kpd_pkg::CFG_W'($urandom_range(20)));
          write_reg(kpd_pkg::CFG_REPEAT_INTERVAL, kpd_pkg::CFG_W'($urandom_range(8)));
        end
      endcase
      send_idle_pct = (s < 2) ? 35 : (s < 4) ? 75 : 0;
      sink_idle_pct = (s < 2) ? 75 : (s < 4) ? 35 : 0;
      if (s == 4) begin
        fork
          begin
            sink_hold = 1'b1;
            repeat (300) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      run_random(155, s == 2);
    end

    settle();
    if (key_events_due.size() != 0)
      flag_error($sformatf("%0d expected words never arrived", key_events_due.size()));
    $display("Ran %0d scans under %0d register writes; checked %0d press and %0d repeat words.",
             n_scans, n_cfg, n_press, n_repeat);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d words outstanding", key_events_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
